@@ rtl/core/css_pkg.sv @@
`timescale 1ns / 1ps

package css_pkg;

    localparam int CAPACITY = 32;
    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int DW       = 32;

    typedef struct packed {
        logic signed [DW-1:0] value;
        logic                 last;
    } item_t;

    typedef struct packed {
        logic signed [DW-1:0] sorted_value;
        logic                 final_res;
    } result_t;

endpackage

@@ rtl/core/cocktail_shaker_sorter.sv @@
`timescale 1ns / 1ps

// Collects signed 32-bit words on the item channel (valid/ready) into a store
// of CAPACITY entries, one word per cycle. The word marked last is stored too;
// the block then drops item_ready and sorts the set in place with alternating
// forward and backward bubble passes through a single-port-read RAM. Each pass
// does one compare-and-write per cycle behind the registered RAM read, and the
// sort stops once a forward pass makes no swap, as for a set already ordered.
// The sorted words then leave on the result channel in ascending order, each
// going through a RAM read, a load of the output register and a handshake; the
// largest is flagged final_res. While result_valid is high and result_ready is
// low the word is held unchanged and the block waits. After the final word is
// taken the count clears and item_ready rises again.
// Words beyond CAPACITY are dropped, a last word included; the set is still
// sorted and sent. Reset clears the count and the sequencer; the store needs
// no clearing since only entries written in the current set are read.
module cocktail_shaker_sorter
    import css_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    typedef enum logic [11:0] {
        S_LOAD   = 12'b0000_0000_0001,
        S_FSTART = 12'b0000_0000_0010,
        S_FFIRST = 12'b0000_0000_0100,
        S_FSTEP  = 12'b0000_0000_1000,
        S_FEND   = 12'b0000_0001_0000,
        S_BSTART = 12'b0000_0010_0000,
        S_BFIRST = 12'b0000_0100_0000,
        S_BSTEP  = 12'b0000_1000_0000,
        S_BEND   = 12'b0001_0000_0000,
        S_ORD    = 12'b0010_0000_0000,
        S_OWAIT  = 12'b0100_0000_0000,
        S_OHOLD  = 12'b1000_0000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        lo_reg, lo_next;
    logic [AW-1:0]        hi_reg, hi_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic signed [DW-1:0] carry_reg, carry_next;
    logic                 swapped_reg, swapped_next;
    result_t              res_reg, res_next;
    logic                 rvalid_reg, rvalid_next;

    logic                 we;
    logic [AW-1:0]        waddr;
    logic [DW-1:0]        wdata;
    logic                 re;
    logic [AW-1:0]        raddr;
    logic [DW-1:0]        rdata;
    logic signed [DW-1:0] rd_s;
    logic                 full;
    logic [CW-1:0]        n_new;

    css_ram #(
        .WIDTH(DW),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_s         = signed'(rdata);
    assign full         = (count_reg == CW'(CAPACITY));
    assign n_new        = full ? count_reg : count_reg + CW'(1);
    assign item_ready   = (state_reg == S_LOAD);
    assign result_valid = rvalid_reg;
    assign result       = res_reg;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        idx_next     = idx_reg;
        carry_next   = carry_reg;
        swapped_next = swapped_reg;
        res_next     = res_reg;
        rvalid_next  = rvalid_reg;
        we           = 1'b0;
        waddr        = idx_reg;
        wdata        = carry_reg;
        re           = 1'b0;
        raddr        = idx_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                if (item_valid)
                begin
                    if (!full)
                    begin
                        we    = 1'b1;
                        waddr = count_reg[AW-1:0];
                        wdata = item.value;
                    end
                    count_next = n_new;
                    if (item.last)
                    begin
                        lo_next    = '0;
                        hi_next    = AW'(n_new - CW'(1));
                        state_next = S_FSTART;
                    end
                end
            end
            S_FSTART:
            begin
                if (lo_reg < hi_reg)
                begin
                    re           = 1'b1;
                    raddr        = lo_reg;
                    idx_next     = lo_reg;
                    swapped_next = 1'b0;
                    state_next   = S_FFIRST;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_ORD;
                end
            end
            S_FFIRST:
            begin
                carry_next = rd_s;
                re         = 1'b1;
                raddr      = idx_reg + AW'(1);
                state_next = S_FSTEP;
            end
            S_FSTEP:
            begin
                we    = 1'b1;
                waddr = idx_reg;
                if (carry_reg > rd_s)
                begin
                    wdata        = rd_s;
                    swapped_next = 1'b1;
                end
                else
                begin
                    wdata      = carry_reg;
                    carry_next = rd_s;
                end
                idx_next = idx_reg + AW'(1);
                if (idx_reg == hi_reg - AW'(1))
                begin
                    state_next = S_FEND;
                end
                else
                begin
                    re    = 1'b1;
                    raddr = idx_reg + AW'(2);
                end
            end
            S_FEND:
            begin
                we    = 1'b1;
                waddr = hi_reg;
                wdata = carry_reg;
                if (!swapped_reg)
                begin
                    idx_next   = '0;
                    state_next = S_ORD;
                end
                else
                begin
                    hi_next    = hi_reg - AW'(1);
                    state_next = S_BSTART;
                end
            end
            S_BSTART:
            begin
                if (lo_reg < hi_reg)
                begin
                    re         = 1'b1;
                    raddr      = hi_reg;
                    idx_next   = hi_reg;
                    state_next = S_BFIRST;
                end
                else
                begin
                    lo_next    = lo_reg + AW'(1);
                    state_next = S_FSTART;
                end
            end
            S_BFIRST:
            begin
                carry_next = rd_s;
                re         = 1'b1;
                raddr      = idx_reg - AW'(1);
                state_next = S_BSTEP;
            end
            S_BSTEP:
            begin
                we    = 1'b1;
                waddr = idx_reg;
                if (rd_s > carry_reg)
                begin
                    wdata = rd_s;
                end
                else
                begin
                    wdata      = carry_reg;
                    carry_next = rd_s;
                end
                idx_next = idx_reg - AW'(1);
                if (idx_reg == lo_reg + AW'(1))
                begin
                    state_next = S_BEND;
                end
                else
                begin
                    re    = 1'b1;
                    raddr = idx_reg - AW'(2);
                end
            end
            S_BEND:
            begin
                we         = 1'b1;
                waddr      = lo_reg;
                wdata      = carry_reg;
                lo_next    = lo_reg + AW'(1);
                state_next = S_FSTART;
            end
            S_ORD:
            begin
                re         = 1'b1;
                raddr      = idx_reg;
                state_next = S_OWAIT;
            end
            S_OWAIT:
            begin
                res_next.sorted_value = rd_s;
                res_next.final_res    = ({1'b0, idx_reg} + (AW+1)'(1)) == (AW+1)'(count_reg);
                rvalid_next           = 1'b1;
                state_next            = S_OHOLD;
            end
            S_OHOLD:
            begin
                if (result_ready)
                begin
                    rvalid_next = 1'b0;
                    idx_next    = idx_reg + AW'(1);
                    if (res_reg.final_res)
                    begin
                        count_next = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_ORD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            count_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        idx_reg     <= idx_next;
        carry_reg   <= carry_next;
        swapped_reg <= swapped_next;
        res_reg     <= res_next;
    end

endmodule

@@ rtl/core/css_ram.sv @@
`timescale 1ns / 1ps

module css_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import css_pkg::*;

    typedef logic signed [DW-1:0] word_t;

    localparam int     RESET_CYCLES = 7;
    localparam int     IDLE_PCT     = 36;
    localparam int     RANDOM_WORDS = 16;
    localparam int     TAIL_CYCLES  = 60;
    localparam int     REPORT_MAX   = 10;
    localparam longint CYCLE_LIMIT  = 400000;
    localparam word_t  MOST_NEG     = {1'b1, {(DW-1){1'b0}}};
    localparam word_t  MOST_POS     = {1'b0, {(DW-1){1'b1}}};

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_ready;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    word_t   loaded_words[$];
    result_t sorted_words[$];
    int      mismatches = 0;
    longint  cycles     = 0;
    bit      steady     = 1'b0;

    cocktail_shaker_sorter i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("cocktail_shaker_sorter verification failed");
            $finish;
        end
    end

    always @(posedge clk)
        result_ready <= steady || ($urandom_range(99) >= IDLE_PCT);

    // stable insertion sort, ascending unless descending is set
    function automatic void sort_words(ref word_t w[$], input bit descending);
        word_t key;
        int    j;
        for (int i = 1; i < w.size(); i++)
        begin
            key = w[i];
            j   = i - 1;
            while (j >= 0 && (descending ? (w[j] < key) : (w[j] > key)))
            begin
                w[j+1] = w[j];
                j--;
            end
            w[j+1] = key;
        end
    endfunction

    function automatic void load_word(input item_t w);
        result_t r;
        if (loaded_words.size() < CAPACITY)
            loaded_words.insert(loaded_words.size(), w.value);
        if (w.last)
        begin
            sort_words(loaded_words, 1'b0);
            foreach (loaded_words[k])
            begin
                r.sorted_value = loaded_words[k];
                r.final_res    = (k == loaded_words.size() - 1);
                sorted_words.insert(sorted_words.size(), r);
            end
            loaded_words.delete();
        end
    endfunction

    function automatic word_t rand_word();
        case ($urandom_range(9))
            0:       return MOST_NEG;
            1:       return MOST_POS;
            2, 3:    return word_t'(int'($urandom_range(8)) - 4);
            default: return word_t'($urandom);
        endcase
    endfunction

    task automatic send_word(input word_t v, input logic l);
        item_t w;
        w = '{value: v, last: l};
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        do
            @(posedge clk);
        while (!item_ready);
        load_word(w);
    endtask

    // the final word of the queue carries last
    task automatic send_set(input word_t w[$]);
        foreach (w[k])
            send_word(w[k], k == w.size() - 1);
        item_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (sorted_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_single_word();
        word_t w[$];
        w = '{MOST_NEG};
        send_set(w);
        w = '{MOST_POS};
        send_set(w);
    endtask

    task automatic test_extremes();
        word_t w[$];
        w = '{MOST_POS, MOST_NEG, 0, -1, 1};
        send_set(w);
    endtask

    task automatic test_equal_values();
        word_t w[$];
        w = '{5, -3, 5, 5, -3, MOST_NEG, MOST_NEG};
        send_set(w);
    endtask

    task automatic test_descending();
        word_t w[$];
        w = '{MOST_POS, 1000, 7, 0, -1, -7, -1000, MOST_NEG};
        send_set(w);
    endtask

    // exactly full, then one word over so the last word is dropped, then well over
    task automatic test_store_full();
        word_t w[$];
        repeat (CAPACITY)
            w.insert(w.size(), rand_word());
        sort_words(w, 1'b0);
        send_set(w);
        w.delete();
        repeat (CAPACITY + 1)
            w.insert(w.size(), rand_word());
        sort_words(w, 1'b1);
        send_set(w);
        w.delete();
        repeat (CAPACITY + 8)
            w.insert(w.size(), rand_word());
        send_set(w);
    endtask

    task automatic test_drain_between_sets();
        word_t w[$];
        repeat (3)
        begin
            w.delete();
            repeat ($urandom_range(6, 2))
                w.insert(w.size(), rand_word());
            send_set(w);
            wait_drained();
        end
    endtask

    task automatic test_back_to_back();
        word_t w[$];
        steady = 1'b1;
        repeat (4)
        begin
            w.delete();
            repeat ($urandom_range(12, 1))
                w.insert(w.size(), rand_word());
            send_set(w);
        end
        wait_drained();
        steady = 1'b0;
    endtask

    task automatic test_random_sets();
        word_t w[$];
        int    sent;
        int    n;
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            w.delete();
            case ($urandom_range(19))
                0:       n = $urandom_range(CAPACITY + 4, CAPACITY + 1);
                1, 2:    n = $urandom_range(CAPACITY, 9);
                default: n = $urandom_range(8, 1);
            endcase
            repeat (n)
                w.insert(w.size(), rand_word());
            case ($urandom_range(3))
                1:       sort_words(w, 1'b0);
                2:       sort_words(w, 1'b1);
                default: ;
            endcase
            send_set(w);
            sent += n;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (sorted_words.size() == 0)
            begin
                if (mismatches < REPORT_MAX)
                    $display("unexpected word: sorted_value %0d final_res %0b",
                             result.sorted_value, result.final_res);
                mismatches++;
            end
            else
            begin
                want = sorted_words.pop_front();
                if (result.sorted_value !== want.sorted_value ||
                    result.final_res !== want.final_res)
                begin
                    if (mismatches < REPORT_MAX)
                        $display("mismatch: sorted_value exp %0d got %0d, final_res exp %0b got %0b",
                                 want.sorted_value, result.sorted_value,
                                 want.final_res, result.final_res);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_word();
        test_extremes();
        test_equal_values();
        test_descending();
        test_store_full();
        test_drain_between_sets();
        test_back_to_back();
        test_random_sets();
        wait_drained();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (mismatches == 0)
            $display("cocktail_shaker_sorter verification clean");
        else
            $display("cocktail_shaker_sorter verification failed");
        $finish;
    end

endmodule
